@@ src/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared widths, types, codes and helpers of the ray/triangle intersect block.
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int CW    = 24;        // coordinate width, Q11.12
   localparam int FRAC  = 12;        // fraction bits
   localparam int PW    = 2 * CW;    // coordinate product
   localparam int NW    = PW + 3;    // plane numerator and denominator, signed
   localparam int DW    = NW - 1;    // positive numerator and denominator
   localparam int QW    = 23;        // distance width
   localparam int RW    = DW + FRAC; // division remainder
   localparam int PTW   = PW - FRAC + 1;
   localparam int EW    = CW + 1;    // edge and offset vectors
   localparam int MW    = 2 * EW + 1;
   localparam int MLW   = 26;        // low part of the edge multiplier split
   localparam int AW    = MW + CW + 2;
   localparam int FTW   = 24;
   localparam int ETW   = 36;
   localparam int CSR_DW = 36;
   localparam int EDGE_LAT = 6;

   localparam logic [FTW-1:0] FACING_RESET = 24'd168;
   localparam logic [ETW-1:0] EDGE_RESET   = 36'd687195;

   localparam logic       CMD_LOAD = 1'b0;
   localparam logic       CMD_TEST = 1'b1;
   localparam logic [1:0] SLOT_P0     = 2'd0;
   localparam logic [1:0] SLOT_P1     = 2'd1;
   localparam logic [1:0] SLOT_P2     = 2'd2;
   localparam logic [1:0] SLOT_NORMAL = 2'd3;
   localparam logic       CSR_FACING = 1'b0;
   localparam logic       CSR_EDGE   = 1'b1;

   typedef logic [2:0][CW-1:0] vec_type;   // [0] x, [1] y, [2] z
   typedef vec_type [3:0] tri_type;        // p0, p1, p2, normal

   typedef struct packed {
      tri_type vecs;
      vec_type org;
      vec_type dir;
   } ray_type;

   typedef struct packed {
      ray_type          ray;
      logic             miss;
      logic             sat;
      logic [RW-1:0]    rem;
      logic [DW-1:0]    den;
      logic [QW-1:0]    q;
   } div_type;

   localparam logic signed [PTW-1:0] SAT_HI = PTW'(8388607);
   localparam logic signed [PTW-1:0] SAT_LO = PTW'(-8388608);

   function automatic logic [CW-1:0] sat24(input logic signed [PTW-1:0] v);
      logic [CW-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[CW-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[CW-1:0];
      end else begin
         r = v[CW-1:0];
      end
      return r;
   endfunction

endpackage

@@ src/rti_if.sv @@
// ----------------------------------------------------------------------------
// rti_if
// Request and response channels of the ray/triangle intersect block.
// ----------------------------------------------------------------------------
interface rti_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic [1:0]        slot;
   logic signed [23:0] vec_x;
   logic signed [23:0] vec_y;
   logic signed [23:0] vec_z;
   logic signed [23:0] dir_x;
   logic signed [23:0] dir_y;
   logic signed [23:0] dir_z;

   modport source (output valid, command, slot, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z,
                   input ready);
   modport sink   (input valid, command, slot, vec_x, vec_y, vec_z, dir_x, dir_y, dir_z,
                   output ready);
endinterface

interface rti_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   logic [22:0]       ray_distance;
   logic signed [23:0] point_x;
   logic signed [23:0] point_y;
   logic signed [23:0] point_z;

   modport source (output valid, hit, ray_distance, point_x, point_y, point_z,
                   input ready);
   modport sink   (input valid, hit, ray_distance, point_x, point_y, point_z,
                   output ready);
endinterface

@@ src/rti_front.sv @@
// ----------------------------------------------------------------------------
// rti_front
// Input register, plane dot products and the facing and behind-plane checks.
// ----------------------------------------------------------------------------
module rti_front
   import rti_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic [FTW-1:0] facing_tol,
   input  logic           in_valid,
   input  ray_type        in_ray,
   output logic           out_valid,
   output div_type        out_div
);

   logic            a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   ray_type         a_ray_ff, b_ray_ff, c_ray_ff;
   logic signed [PW-1:0] np_ff [3];
   logic signed [PW-1:0] nd_ff [3];
   logic signed [PW-1:0] no_ff [3];
   logic signed [NW-1:0] c_num_ff, c_den_ff;
   logic signed [NW-1:0] num_in, den_in;
   div_type         d_div_ff, d_div_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_comb begin
      num_in = NW'(no_ff[0]) + NW'(no_ff[1]) + NW'(no_ff[2])
             - NW'(np_ff[0]) - NW'(np_ff[1]) - NW'(np_ff[2]);
      den_in = -(NW'(nd_ff[0]) + NW'(nd_ff[1]) + NW'(nd_ff[2]));
      d_div_in.ray  = c_ray_ff;
      // zero facing term is always a miss, whatever the tolerance
      d_div_in.miss = (c_den_ff <= 0) ||
                      (c_den_ff < $signed({(NW-FTW)'(0), facing_tol})) ||
                      c_num_ff[NW-1];
      d_div_in.sat  = (DW + QW - FRAC)'(c_num_ff[DW-1:0]) >=
                      {c_den_ff[DW-1:0], (QW-FRAC)'(0)};
      d_div_in.rem  = {c_num_ff[DW-1:0], FRAC'(0)};
      d_div_in.den  = c_den_ff[DW-1:0];
      d_div_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ray_ff <= in_ray;
         b_ray_ff <= a_ray_ff;
         c_ray_ff <= b_ray_ff;
         for (int k = 0; k < 3; k++) begin
            np_ff[k] <= $signed(a_ray_ff.vecs[SLOT_NORMAL][k]) *
                        $signed(a_ray_ff.vecs[SLOT_P0][k]);
            nd_ff[k] <= $signed(a_ray_ff.vecs[SLOT_NORMAL][k]) * $signed(a_ray_ff.dir[k]);
            no_ff[k] <= $signed(a_ray_ff.vecs[SLOT_NORMAL][k]) * $signed(a_ray_ff.org[k]);
         end
         c_num_ff <= num_in;
         c_den_ff <= den_in;
         d_div_ff <= d_div_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_div   = d_div_ff;

endmodule

@@ src/rti_div.sv @@
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per pipeline stage, for the distance t.
// ----------------------------------------------------------------------------
module rti_div
   import rti_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  div_type       in_div,
   output logic          out_valid,
   output ray_type       out_ray,
   output logic          out_miss,
   output logic [QW-1:0] out_t
);

   localparam int CMPW = DW + QW;

   logic    valid_ff [QW];
   div_type div_ff   [QW];

   genvar i;
   for (i = 0; i < QW; i++) begin : g_step
      localparam int B = QW - 1 - i;
      logic          src_valid;
      div_type       src, div_in;
      logic [CMPW-1:0] shifted;

      if (i == 0) begin : g_first
         assign src_valid = in_valid;
         assign src       = in_div;
      end else begin : g_next
         assign src_valid = valid_ff[i-1];
         assign src       = div_ff[i-1];
      end

      always_comb begin
         shifted = CMPW'(src.den) << B;
         div_in  = src;
         if (CMPW'(src.rem) >= shifted) begin
            div_in.rem  = src.rem - shifted[RW-1:0];
            div_in.q[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[i] <= div_in;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_ray   = div_ff[QW-1].ray;
   assign out_miss  = div_ff[QW-1].miss;
   // quotient beyond the distance range saturates to all ones
   assign out_t     = div_ff[QW-1].sat ? '1 : div_ff[QW-1].q;

endmodule

@@ src/rti_point.sv @@
// ----------------------------------------------------------------------------
// rti_point
// Hit point origin + dir * t, floored to Q12 and saturated.
// ----------------------------------------------------------------------------
module rti_point
   import rti_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  ray_type       in_ray,
   input  logic          in_miss,
   input  logic [QW-1:0] in_t,
   output logic          out_valid,
   output tri_type       out_tri,
   output logic          out_miss,
   output logic [QW-1:0] out_t,
   output vec_type       out_pt
);

   logic            p1_valid_ff, p2_valid_ff;
   ray_type         p1_ray_ff;
   logic            p1_miss_ff, p2_miss_ff;
   logic [QW-1:0]   p1_t_ff, p2_t_ff;
   tri_type         p2_tri_ff;
   logic signed [PW-1:0] pr_ff [3];
   vec_type         pt_ff, pt_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pt_in[k] = sat24(PTW'($signed(p1_ray_ff.org[k])) + PTW'(pr_ff[k] >>> FRAC));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= in_valid;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ray_ff  <= in_ray;
         p1_miss_ff <= in_miss;
         p1_t_ff    <= in_t;
         for (int k = 0; k < 3; k++) begin
            pr_ff[k] <= $signed(in_ray.dir[k]) * $signed({1'b0, in_t});
         end
         p2_tri_ff  <= p1_ray_ff.vecs;
         p2_miss_ff <= p1_miss_ff;
         p2_t_ff    <= p1_t_ff;
         pt_ff      <= pt_in;
      end
   end

   assign out_valid = p2_valid_ff;
   assign out_tri   = p2_tri_ff;
   assign out_miss  = p2_miss_ff;
   assign out_t     = p2_t_ff;
   assign out_pt    = pt_ff;

endmodule

@@ src/rti_edge.sv @@
// ----------------------------------------------------------------------------
// rti_edge
// Inside test of the hit point against one triangle edge.
// ----------------------------------------------------------------------------
module rti_edge
   import rti_pkg::*;
(
   input  logic           clock,
   input  logic           adv,
   input  logic [ETW-1:0] edge_tol,
   input  vec_type        va,
   input  vec_type        vb,
   input  vec_type        nrm,
   input  vec_type        pt,
   output logic           fail
);

   logic signed [EW-1:0]   v_ff [3];
   logic signed [EW-1:0]   e_ff [3];
   logic signed [2*EW-1:0] ca_ff [3];
   logic signed [2*EW-1:0] cb_ff [3];
   logic signed [MW-1:0]   m_ff [3];
   logic signed [MW-1:0]   lo_ff [3];
   logic signed [MW-MLW+CW-1:0] hi_ff [3];
   logic signed [AW-1:0]   pp_ff [3];
   vec_type                n1_ff, n2_ff, n3_ff;
   logic signed [AW-1:0]   acc;
   logic                   fail_ff;

   assign acc = $signed({(AW-ETW)'(0), edge_tol}) + pp_ff[0] + pp_ff[1] + pp_ff[2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            v_ff[k] <= EW'($signed(va[k])) - EW'($signed(pt[k]));
            e_ff[k] <= EW'($signed(vb[k])) - EW'($signed(va[k]));
         end
         n1_ff <= nrm;
         // cross(v, e)
         ca_ff[0] <= v_ff[1] * e_ff[2];
         cb_ff[0] <= v_ff[2] * e_ff[1];
         ca_ff[1] <= v_ff[2] * e_ff[0];
         cb_ff[1] <= v_ff[0] * e_ff[2];
         ca_ff[2] <= v_ff[0] * e_ff[1];
         cb_ff[2] <= v_ff[1] * e_ff[0];
         n2_ff <= n1_ff;
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= MW'(ca_ff[k]) - MW'(cb_ff[k]);
         end
         n3_ff <= n2_ff;
         // split multiply by the normal
         for (int k = 0; k < 3; k++) begin
            lo_ff[k] <= $signed({1'b0, m_ff[k][MLW-1:0]}) * $signed(n3_ff[k]);
            hi_ff[k] <= $signed(m_ff[k][MW-1:MLW]) * $signed(n3_ff[k]);
         end
         for (int k = 0; k < 3; k++) begin
            pp_ff[k] <= (AW'(hi_ff[k]) <<< MLW) + AW'(lo_ff[k]);
         end
         fail_ff <= acc[AW-1];
      end
   end

   assign fail = fail_ff;

endmodule

@@ src/ray_triangle_intersect.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Fixed point Q11.12 ray against triangle test with plane and edge checks.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the response side takes results. A
// load request stores one triangle vector at acceptance and gives no response;
// it applies to every test request accepted after it. A test request passes the
// input register, loaded at acceptance, and the plane dot products, then the
// one-bit-per-stage divider that forms t, the hit point, the edge tests and
// the output register. The whole pipeline holds while a response waits.
module ray_triangle_intersect
   import rti_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rti_req_if.sink           req_bus,
   rti_rsp_if.source         rsp_bus,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   tri_type         tri_ff;
   logic [FTW-1:0]  facing_ff;
   logic [ETW-1:0]  edge_ff;
   logic            adv, req_take;
   ray_type         req_ray;

   logic            fr_valid;
   div_type         fr_div;
   logic            dv_valid, dv_miss;
   ray_type         dv_ray;
   logic [QW-1:0]   dv_t;
   logic            pt_valid, pt_miss;
   tri_type         pt_tri;
   logic [QW-1:0]   pt_t;
   vec_type         pt_vec;
   logic [2:0]      edge_fail;

   logic            sd_valid_ff [EDGE_LAT];
   logic            sd_miss_ff  [EDGE_LAT];
   logic [QW-1:0]   sd_t_ff     [EDGE_LAT];
   vec_type         sd_pt_ff    [EDGE_LAT];

   logic            out_valid_ff, hit_ff, hit_in;
   logic [QW-1:0]   dist_ff;
   vec_type         point_ff;

   assign adv      = !out_valid_ff || rsp_bus.ready;
   assign req_take = req_bus.valid && adv;
   assign req_bus.ready = adv;
   assign req_ray.vecs = tri_ff;
   assign req_ray.org = {req_bus.vec_z, req_bus.vec_y, req_bus.vec_x};
   assign req_ray.dir = {req_bus.dir_z, req_bus.dir_y, req_bus.dir_x};

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_ff    <= '0;
         facing_ff <= FACING_RESET;
         edge_ff   <= EDGE_RESET;
      end else begin
         if (req_take && req_bus.command == CMD_LOAD) begin
            tri_ff[req_bus.slot] <= {req_bus.vec_z, req_bus.vec_y, req_bus.vec_x};
         end
         if (csr_we) begin
            case (csr_index)
               CSR_FACING: facing_ff <= csr_wdata[FTW-1:0];
               CSR_EDGE:   edge_ff   <= csr_wdata[ETW-1:0];
               default:    ;
            endcase
         end
      end
   end

   rti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .facing_tol (facing_ff),
      .in_valid   (req_take && req_bus.command == CMD_TEST),
      .in_ray     (req_ray),
      .out_valid  (fr_valid),
      .out_div    (fr_div)
   );

   rti_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_div    (fr_div),
      .out_valid (dv_valid),
      .out_ray   (dv_ray),
      .out_miss  (dv_miss),
      .out_t     (dv_t)
   );

   rti_point u_point (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_ray    (dv_ray),
      .in_miss   (dv_miss),
      .in_t      (dv_t),
      .out_valid (pt_valid),
      .out_tri   (pt_tri),
      .out_miss  (pt_miss),
      .out_t     (pt_t),
      .out_pt    (pt_vec)
   );

   rti_edge u_edge01 (
      .clock (clock), .adv (adv), .edge_tol (edge_ff),
      .va (pt_tri[SLOT_P0]), .vb (pt_tri[SLOT_P1]), .nrm (pt_tri[SLOT_NORMAL]),
      .pt (pt_vec), .fail (edge_fail[0])
   );

   rti_edge u_edge12 (
      .clock (clock), .adv (adv), .edge_tol (edge_ff),
      .va (pt_tri[SLOT_P1]), .vb (pt_tri[SLOT_P2]), .nrm (pt_tri[SLOT_NORMAL]),
      .pt (pt_vec), .fail (edge_fail[1])
   );

   rti_edge u_edge20 (
      .clock (clock), .adv (adv), .edge_tol (edge_ff),
      .va (pt_tri[SLOT_P2]), .vb (pt_tri[SLOT_P0]), .nrm (pt_tri[SLOT_NORMAL]),
      .pt (pt_vec), .fail (edge_fail[2])
   );

   // side data rides along while the edge tests run
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < EDGE_LAT; s++) begin
            sd_valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         sd_valid_ff[0] <= pt_valid;
         for (int s = 1; s < EDGE_LAT; s++) begin
            sd_valid_ff[s] <= sd_valid_ff[s-1];
         end
         out_valid_ff <= sd_valid_ff[EDGE_LAT-1];
      end
   end

   assign hit_in = !sd_miss_ff[EDGE_LAT-1] && (edge_fail == 3'b000);

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_miss_ff[0] <= pt_miss;
         sd_t_ff[0]    <= pt_t;
         sd_pt_ff[0]   <= pt_vec;
         for (int s = 1; s < EDGE_LAT; s++) begin
            sd_miss_ff[s] <= sd_miss_ff[s-1];
            sd_t_ff[s]    <= sd_t_ff[s-1];
            sd_pt_ff[s]   <= sd_pt_ff[s-1];
         end
         hit_ff   <= hit_in;
         dist_ff  <= hit_in ? sd_t_ff[EDGE_LAT-1] : '0;
         point_ff <= hit_in ? sd_pt_ff[EDGE_LAT-1] : '0;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.hit          = hit_ff;
   assign rsp_bus.ray_distance = dist_ff;
   assign rsp_bus.point_x      = point_ff[0];
   assign rsp_bus.point_y      = point_ff[1];
   assign rsp_bus.point_z      = point_ff[2];

endmodule

@@ src/rti_checker.sv @@
// ----------------------------------------------------------------------------
// rti_checker
// Port level checks of the ray/triangle intersect block.
// ----------------------------------------------------------------------------
module rti_checker
   import rti_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              hit,
   input logic [QW-1:0]     distance,
   input logic [CW-1:0]     px,
   input logic [CW-1:0]     py,
   input logic [CW-1:0]     pz
);

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(distance) &&
      $stable(px) && $stable(py) && $stable(pz))
      else $error("response changed while stalled");

   // a miss carries zero distance and point
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !hit |-> distance == '0 && px == '0 && py == '0 && pz == '0)
      else $error("miss response with nonzero fields");

   // requests flow whenever no response waits
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind ray_triangle_intersect rti_checker u_rti_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .hit       (rsp_bus.hit),
   .distance  (rsp_bus.ray_distance),
   .px        (rsp_bus.point_x),
   .py        (rsp_bus.point_y),
   .pz        (rsp_bus.point_z)
);
